[hdl/info_frame_deframer_destuffer_macros.svh]
// Assertion macros used by the checker file of the frame receiver.
`ifndef INFO_FRAME_DEFRAMER_DESTUFFER_MACROS_SVH
`define INFO_FRAME_DEFRAMER_DESTUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFDD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifdd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IFDD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifdd assertion failed");

`endif

[hdl/ifdd_pkg.sv]
// Package with the byte codes, event codes and limits of the frame receiver.
package ifdd_pkg;

    localparam int MAX_BODY  = 4096;
    localparam int LEN_W     = 13;
    localparam int ADDR_W    = 3;

    typedef logic [7:0]       t_byte;
    typedef logic [LEN_W-1:0] t_len;

    localparam t_byte B_FLAG = 8'h7E;
    localparam t_byte B_ESC  = 8'h7D;
    localparam t_byte B_XOR  = 8'h20;
    localparam t_byte C_SET  = 8'h03;
    localparam t_byte C_UA   = 8'h07;
    localparam t_byte C_DISC = 8'h0B;
    localparam t_byte C_I0   = 8'h00;
    localparam t_byte C_I1   = 8'h80;
    localparam t_byte C_RR0  = 8'hAA;
    localparam t_byte C_RR1  = 8'hAB;
    localparam t_byte C_REJ0 = 8'h54;
    localparam t_byte C_REJ1 = 8'h55;

    localparam logic [2:0] EV_PAYLOAD  = 3'd0;
    localparam logic [2:0] EV_ACCEPT   = 3'd1;
    localparam logic [2:0] EV_REJECT   = 3'd2;
    localparam logic [2:0] EV_HDR_ERR  = 3'd3;
    localparam logic [2:0] EV_CONNECT  = 3'd4;
    localparam logic [2:0] EV_DISCONN  = 3'd5;

    localparam logic REG_LINK_ADDRESS = 1'b0;
    localparam logic REG_MAX_BODY_LEN = 1'b1;

    localparam t_byte RST_LINK_ADDRESS = 8'h03;
    localparam t_len  MAX_BODY_LEN     = t_len'(MAX_BODY);

endpackage

[hdl/info_frame_deframer_destuffer.sv]
// Receiver for byte-stuffed link frames with address, control, header check and XOR body check.
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid / o_in_stall  i_rx_byte
//   out       output     o_out_valid / i_out_stall o_event_code, o_payload_byte,
//                                                 o_send_reply, o_reply_control,
//                                                 o_frame_length
//   config    input      APB write/read           paddr, pwdata, prdata
//
// One byte per cycle while the result is not stalled; an accepted byte is held in the input
// register, and its result is loaded into the result register when the parse stage advances.
// Reset is synchronous and active low; it clears the parser, the registers to their
// defaults, and both pipeline valid bits. A stalled result holds the parse stage, and
// the input register still takes one more byte before the input side stalls.
module info_frame_deframer_destuffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_event_code,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_send_reply,
    output logic [7:0]                    o_reply_control,
    output logic [ifdd_pkg::LEN_W-1:0]    o_frame_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifdd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ifdd_pkg::*;

    localparam logic [2:0] ST_WAIT = 3'd0;
    localparam logic [2:0] ST_FLAG = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_CTRL = 3'd3;
    localparam logic [2:0] ST_BODY = 3'd4;
    localparam logic [2:0] ST_ESC  = 3'd5;

    // Configuration registers.
    t_byte r_link_address;
    t_len  r_max_body_len;

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;

    // Parser state.
    logic [2:0] r_state,      n_state;
    logic       r_seq,        n_seq;
    t_byte      r_held,       n_held;
    logic       r_held_valid, n_held_valid;
    t_byte      r_check,      n_check;
    t_len       r_count,      n_count;
    logic       r_overlong,   n_overlong;

    // Result register.
    logic       r_out_valid,  n_out_valid;
    logic [2:0] r_event,      n_event;
    t_byte      r_pay,        n_pay;
    logic       r_reply,      n_reply;
    t_byte      r_rctl,       n_rctl;
    t_len       r_len,        n_len;

    logic  proc_go;
    logic  cfg_wr;
    t_len  limit;
    t_byte take_val;
    logic  take;

    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;
    assign proc_go     = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & ~proc_go;
    assign limit       = (r_max_body_len > MAX_BODY_LEN) ? MAX_BODY_LEN : r_max_body_len;

    always_comb begin
        unique case (paddr[2])
            REG_LINK_ADDRESS: prdata = {24'd0, r_link_address};
            REG_MAX_BODY_LEN: prdata = {{(32-LEN_W){1'b0}}, r_max_body_len};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_address <= RST_LINK_ADDRESS;
            r_max_body_len <= MAX_BODY_LEN;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LINK_ADDRESS: r_link_address <= pwdata[7:0];
                REG_MAX_BODY_LEN: r_max_body_len <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_seq        = r_seq;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_check      = r_check;
        n_count      = r_count;
        n_overlong   = r_overlong;
        n_out_valid  = 1'b0;
        n_event      = EV_PAYLOAD;
        n_pay        = 8'd0;
        n_reply      = 1'b0;
        n_rctl       = 8'd0;
        n_len        = '0;
        take         = 1'b0;
        take_val     = r_in_byte;

        unique case (r_state)
            ST_WAIT: begin
                if (r_in_byte == B_FLAG) n_state = ST_FLAG;
            end
            ST_FLAG: begin
                // The address compare wins even when the address equals the flag.
                if (r_in_byte == r_link_address) n_state = ST_ADDR;
                else if (r_in_byte != B_FLAG)    n_state = ST_WAIT;
            end
            ST_ADDR: begin
                if (r_in_byte == C_I0 || r_in_byte == C_I1) begin
                    n_seq   = (r_in_byte == C_I1);
                    n_state = ST_CTRL;
                end else if (r_in_byte == B_FLAG) begin
                    n_state = ST_FLAG;
                end else if (r_in_byte == C_SET) begin
                    n_state     = ST_WAIT;
                    n_out_valid = 1'b1;
                    n_event     = EV_CONNECT;
                    n_reply     = 1'b1;
                    n_rctl      = C_UA;
                end else if (r_in_byte == C_DISC) begin
                    n_state     = ST_WAIT;
                    n_out_valid = 1'b1;
                    n_event     = EV_DISCONN;
                    n_reply     = 1'b1;
                    n_rctl      = C_DISC;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_CTRL: begin
                if (r_in_byte == (r_link_address ^ (r_seq ? C_I1 : C_I0))) begin
                    n_state      = ST_BODY;
                    n_held       = 8'd0;
                    n_held_valid = 1'b0;
                    n_check      = 8'd0;
                    n_count      = '0;
                    n_overlong   = 1'b0;
                end else if (r_in_byte == B_FLAG) begin
                    n_state = ST_FLAG;
                end else begin
                    n_state     = ST_WAIT;
                    n_out_valid = 1'b1;
                    n_event     = EV_HDR_ERR;
                end
            end
            ST_BODY: begin
                if (r_in_byte == B_FLAG) begin
                    n_out_valid = 1'b1;
                    n_reply     = 1'b1;
                    n_len       = r_count - t_len'(r_held_valid);
                    if (!r_overlong && r_held_valid && r_held == r_check) begin
                        n_state = ST_WAIT;
                        n_event = EV_ACCEPT;
                        n_rctl  = r_seq ? C_RR1 : C_RR0;
                    end else begin
                        n_state = ST_FLAG;
                        n_event = EV_REJECT;
                        n_rctl  = r_seq ? C_REJ1 : C_REJ0;
                    end
                end else if (r_in_byte == B_ESC) begin
                    n_state = ST_ESC;
                end else begin
                    take = 1'b1;
                end
            end
            ST_ESC: begin
                n_state = ST_BODY;
                take    = 1'b1;
                if (r_in_byte != B_ESC && r_in_byte != B_FLAG) take_val = r_in_byte ^ B_XOR;
            end
            default: n_state = ST_WAIT;
        endcase

        // Body bytes are delivered one late so that the check byte never leaves.
        if (take) begin
            if (r_overlong || r_count >= limit) begin
                n_overlong = 1'b1;
            end else begin
                if (r_held_valid) begin
                    n_out_valid = 1'b1;
                    n_event     = EV_PAYLOAD;
                    n_pay       = r_held;
                    n_check     = r_check ^ r_held;
                end
                n_held       = take_val;
                n_held_valid = 1'b1;
                n_count      = r_count + t_len'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_state      <= ST_WAIT;
            r_seq        <= 1'b0;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_check      <= 8'd0;
            r_count      <= '0;
            r_overlong   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (proc_go) begin
                r_state      <= n_state;
                r_seq        <= n_seq;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_check      <= n_check;
                r_count      <= n_count;
                r_overlong   <= n_overlong;
                r_out_valid  <= n_out_valid;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_in_byte <= i_rx_byte;
        if (proc_go) begin
            r_event <= n_event;
            r_pay   <= n_pay;
            r_reply <= n_reply;
            r_rctl  <= n_rctl;
            r_len   <= n_len;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_code    = r_event;
    assign o_payload_byte  = r_pay;
    assign o_send_reply    = r_reply;
    assign o_reply_control = r_rctl;
    assign o_frame_length  = r_len;

endmodule

[hdl/ifdd_checker.sv]
// Port-level assertion checker for the frame receiver and its bind statement.
`include "info_frame_deframer_destuffer_macros.svh"

module ifdd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [2:0]                  o_event_code,
    input logic [7:0]                  o_payload_byte,
    input logic                        o_send_reply,
    input logic [7:0]                  o_reply_control,
    input logic [ifdd_pkg::LEN_W-1:0]  o_frame_length
);
    import ifdd_pkg::*;

    // A stalled result must not change until it is taken.
    `IFDD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_code) && $stable(o_payload_byte) && $stable(o_reply_control) && $stable(o_frame_length))

    // A reply is requested exactly for end-of-frame, connect and disconnect events.
    `IFDD_ASSERT_SAME(a_reply_kind, i_clk, i_rst_n, o_out_valid, o_send_reply == (o_event_code == EV_ACCEPT || o_event_code == EV_REJECT || o_event_code == EV_CONNECT || o_event_code == EV_DISCONN))

    // The reply control byte matches the event that carries it.
    `IFDD_ASSERT_SAME(a_accept_ctl, i_clk, i_rst_n, o_out_valid && o_event_code == EV_ACCEPT, o_reply_control == C_RR0 || o_reply_control == C_RR1)
    `IFDD_ASSERT_SAME(a_reject_ctl, i_clk, i_rst_n, o_out_valid && o_event_code == EV_REJECT, o_reply_control == C_REJ0 || o_reply_control == C_REJ1)

    // Frame lengths never exceed the largest body.
    `IFDD_ASSERT_SAME(a_len_range, i_clk, i_rst_n, o_out_valid, o_frame_length <= MAX_BODY_LEN)

endmodule

bind info_frame_deframer_destuffer ifdd_checker u_ifdd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_event_code    (o_event_code),
    .o_payload_byte  (o_payload_byte),
    .o_send_reply    (o_send_reply),
    .o_reply_control (o_reply_control),
    .o_frame_length  (o_frame_length)
);

[bench/info_frame_deframer_destuffer_tb.sv]
// Self-checking testbench for the byte-stuffed frame receiver, with its own frame parser model.
module info_frame_deframer_destuffer_tb;
    import ifdd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int PRINT_LIMIT  = 100;
    localparam int LONG_BODY    = 64;

    localparam logic [2:0] PS_WAIT = 3'd0;
    localparam logic [2:0] PS_FLAG = 3'd1;
    localparam logic [2:0] PS_ADDR = 3'd2;
    localparam logic [2:0] PS_CTRL = 3'd3;
    localparam logic [2:0] PS_BODY = 3'd4;
    localparam logic [2:0] PS_ESC  = 3'd5;

    typedef struct {
        logic [2:0] code;
        t_byte      payload;
        logic       reply;
        t_byte      reply_ctl;
        t_len       length;
    } t_frame_event;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_byte               i_rx_byte   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [2:0]          o_event_code;
    t_byte               o_payload_byte;
    logic                o_send_reply;
    t_byte               o_reply_control;
    t_len                o_frame_length;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Parser model state and its copy of the registers.
    logic [2:0]   rx_state      = PS_WAIT;
    logic         rx_seq        = 1'b0;
    t_byte        rx_held       = '0;
    logic         rx_held_valid = 1'b0;
    t_byte        rx_check      = '0;
    t_len         rx_count      = '0;
    logic         rx_overlong   = 1'b0;
    t_byte        cfg_link_address = RST_LINK_ADDRESS;
    t_len         cfg_max_len      = MAX_BODY_LEN;

    t_frame_event expected_events[$];
    t_frame_event want_ev;
    int           error_count = 0;
    int           cycle_count = 0;
    int           bytes_sent  = 0;
    int           stall_left  = 0;
    bit           idle_on     = 1'b1;

    info_frame_deframer_destuffer i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (error_count < PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s expected 0x%0h got 0x%0h",
                     cycle_count, what, want, got);
        end
        error_count++;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            report_mismatch(what, want, got);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic void push_event(input logic [2:0] code, input t_byte payload,
                                       input logic reply, input t_byte reply_ctl,
                                       input t_len length);
        t_frame_event ev;
        ev.code      = code;
        ev.payload   = payload;
        ev.reply     = reply;
        ev.reply_ctl = reply_ctl;
        ev.length    = length;
        expected_events.push_back(ev);
    endfunction

    // A body byte releases the byte held before it; the last one held is the check byte.
    function automatic void take_body_byte(input t_byte b);
        t_len limit;
        limit = (cfg_max_len > MAX_BODY_LEN) ? MAX_BODY_LEN : cfg_max_len;
        if (rx_overlong || rx_count >= limit) begin
            rx_overlong = 1'b1;
            return;
        end
        if (rx_held_valid) begin
            push_event(EV_PAYLOAD, rx_held, 1'b0, 8'h00, '0);
            rx_check ^= rx_held;
        end
        rx_held       = b;
        rx_held_valid = 1'b1;
        rx_count++;
    endfunction

    function automatic void frame_parse_step(input t_byte b);
        t_len length;
        logic ok;
        case (rx_state)
            PS_WAIT: begin
                if (b == B_FLAG) rx_state = PS_FLAG;
            end
            PS_FLAG: begin
                // The address match wins even when the address is the flag byte.
                if (b == cfg_link_address) rx_state = PS_ADDR;
                else if (b != B_FLAG) rx_state = PS_WAIT;
            end
            PS_ADDR: begin
                if (b == C_I0 || b == C_I1) begin
                    rx_seq   = (b == C_I1);
                    rx_state = PS_CTRL;
                end else if (b == B_FLAG) begin
                    rx_state = PS_FLAG;
                end else if (b == C_SET) begin
                    rx_state = PS_WAIT;
                    push_event(EV_CONNECT, 8'h00, 1'b1, C_UA, '0);
                end else if (b == C_DISC) begin
                    rx_state = PS_WAIT;
                    push_event(EV_DISCONN, 8'h00, 1'b1, C_DISC, '0);
                end else begin
                    rx_state = PS_WAIT;
                end
            end
            PS_CTRL: begin
                if (b == (cfg_link_address ^ (rx_seq ? C_I1 : C_I0))) begin
                    rx_state      = PS_BODY;
                    rx_held       = '0;
                    rx_held_valid = 1'b0;
                    rx_check      = '0;
                    rx_count      = '0;
                    rx_overlong   = 1'b0;
                end else if (b == B_FLAG) begin
                    rx_state = PS_FLAG;
                end else begin
                    rx_state = PS_WAIT;
                    push_event(EV_HDR_ERR, 8'h00, 1'b0, 8'h00, '0);
                end
            end
            PS_BODY: begin
                if (b == B_FLAG) begin
                    length = rx_count - t_len'(rx_held_valid);
                    ok     = !rx_overlong && rx_held_valid && rx_held == rx_check;
                    if (ok) begin
                        rx_state = PS_WAIT;
                        push_event(EV_ACCEPT, 8'h00, 1'b1, rx_seq ? C_RR1 : C_RR0, length);
                    end else begin
                        rx_state = PS_FLAG;
                        push_event(EV_REJECT, 8'h00, 1'b1, rx_seq ? C_REJ1 : C_REJ0, length);
                    end
                end else if (b == B_ESC) begin
                    rx_state = PS_ESC;
                end else begin
                    take_body_byte(b);
                end
            end
            PS_ESC: begin
                rx_state = PS_BODY;
                take_body_byte((b == B_ESC || b == B_FLAG) ? b : b ^ B_XOR);
            end
            default: begin
                rx_state = PS_WAIT;
            end
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result with none expected, event_code", 0, o_event_code);
            end else begin
                want_ev = expected_events.pop_front();
                check_field("event_code", want_ev.code, o_event_code);
                check_field("payload_byte", want_ev.payload, o_payload_byte);
                check_field("send_reply", want_ev.reply, o_send_reply);
                check_field("reply_control", want_ev.reply_ctl, o_reply_control);
                check_field("frame_length", want_ev.length, o_frame_length);
            end
        end
    end

    task automatic send_byte(input t_byte b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        frame_parse_step(b);
        bytes_sent++;
    endtask

    task automatic send_line(input t_byte line[$]);
        foreach (line[i]) begin
            send_byte(line[i]);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_LINK_ADDRESS) ? 32'h0000_00FF : 32'h0000_1FFF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_LINK_ADDRESS) cfg_link_address = t_byte'(value);
        else cfg_max_len = t_len'(value);
        // Read the register back through a second transfer.
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata & mask) != (value & mask)) begin
            report_mismatch("register readback", value & mask, prdata & mask);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_byte pick_body_byte();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0: return B_FLAG;
                1: return B_ESC;
                2: return B_FLAG ^ B_XOR;
                3: return B_ESC ^ B_XOR;
                4: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return t_byte'($urandom);
    endfunction

    // Flag and escape bytes must be escaped; other bytes are sometimes escaped too.
    function automatic void stuff_byte(ref t_byte line[$], input t_byte d);
        if (d == B_FLAG || d == B_ESC) begin
            line.push_back(B_ESC);
            line.push_back(d);
        end else if ($urandom_range(0, 9) == 0 && (d ^ B_XOR) != B_FLAG
                     && (d ^ B_XOR) != B_ESC) begin
            line.push_back(B_ESC);
            line.push_back(d ^ B_XOR);
        end else begin
            line.push_back(d);
        end
    endfunction

    task automatic test_header_and_frames();
        send_line({B_FLAG, RST_LINK_ADDRESS, C_SET});
        send_line({B_FLAG, RST_LINK_ADDRESS, C_DISC});
        // A flag inside the header restarts it, then an empty body is rejected.
        send_line({B_FLAG, RST_LINK_ADDRESS, B_FLAG, RST_LINK_ADDRESS, C_I0,
                   RST_LINK_ADDRESS ^ C_I0, B_FLAG});
        // After a reject the parser already sits past the opening flag.
        send_line({RST_LINK_ADDRESS, C_I1, RST_LINK_ADDRESS ^ C_I1,
                   B_ESC, B_FLAG ^ B_XOR, B_ESC, B_ESC, B_ESC, B_FLAG, B_ESC, B_ESC, B_FLAG});
        send_line({B_FLAG, RST_LINK_ADDRESS, C_I0, RST_LINK_ADDRESS ^ C_I0, 8'h00, B_FLAG});
        send_line({B_FLAG, RST_LINK_ADDRESS, C_I1, RST_LINK_ADDRESS ^ C_I1,
                   8'h12, 8'h34, 8'h00, B_FLAG});
        send_line({B_FLAG, RST_LINK_ADDRESS, C_I0, 8'h55});
        send_line({B_FLAG, RST_LINK_ADDRESS, 8'h11});
        wait_idle();
    endtask

    task automatic test_address_and_limit_extremes();
        t_byte line[$];
        // Address equal to the flag byte, and a zero limit that makes any body overlong.
        write_register(REG_LINK_ADDRESS, B_FLAG);
        write_register(REG_MAX_BODY_LEN, 0);
        send_line({B_FLAG, B_FLAG, C_I0, B_FLAG ^ C_I0, 8'h11, B_FLAG, B_FLAG, C_SET});
        wait_idle();
        write_register(REG_LINK_ADDRESS, 8'hFF);
        write_register(REG_MAX_BODY_LEN, 1);
        send_line({B_FLAG, 8'hFF, C_I1, 8'hFF ^ C_I1, 8'h00, B_FLAG});
        send_line({B_FLAG, 8'hFF, C_I0, 8'hFF ^ C_I0, 8'h12, 8'h12, B_FLAG});
        wait_idle();
        // The largest register value acts as the full body size, far above this body.
        write_register(REG_LINK_ADDRESS, 8'h00);
        write_register(REG_MAX_BODY_LEN, 32'h1FFF);
        line = {B_FLAG, 8'h00, C_I0, 8'h00 ^ C_I0};
        repeat (LONG_BODY) stuff_byte(line, t_byte'($urandom));
        line.push_back(B_FLAG);
        send_line(line);
        wait_idle();
    endtask

    task automatic send_random_frame();
        t_byte line[$];
        t_byte addr;
        t_byte ctl;
        t_byte hdr;
        t_byte chk;
        t_byte d;
        int    nbody;
        int    lim;
        int    top;
        int    r;
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 4)) line.push_back(t_byte'($urandom));
        end
        addr = ($urandom_range(0, 99) < 92) ? cfg_link_address : t_byte'($urandom);
        r = $urandom_range(0, 99);
        if (r < 42) ctl = C_I0;
        else if (r < 84) ctl = C_I1;
        else if (r < 90) ctl = C_SET;
        else if (r < 95) ctl = C_DISC;
        else ctl = t_byte'($urandom);
        hdr = addr ^ ctl;
        if ($urandom_range(0, 99) < 6) hdr = hdr ^ t_byte'($urandom_range(1, 255));
        line.push_back(B_FLAG);
        line.push_back(addr);
        line.push_back(ctl);
        if (ctl == C_I0 || ctl == C_I1) begin
            line.push_back(hdr);
            lim   = (cfg_max_len > MAX_BODY_LEN) ? MAX_BODY : int'(cfg_max_len);
            top   = (lim < 37) ? lim + 3 : 40;
            nbody = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 10)
                                                 : $urandom_range(0, top);
            chk = 8'h00;
            for (int i = 1; i < nbody; i++) begin
                d = pick_body_byte();
                chk ^= d;
                stuff_byte(line, d);
            end
            if (nbody > 0) begin
                if ($urandom_range(0, 99) < 8) chk ^= t_byte'($urandom_range(1, 255));
                stuff_byte(line, chk);
            end
            // Now and then the closing flag is lost and the next frame's flag ends the body.
            if ($urandom_range(0, 99) >= 5) line.push_back(B_FLAG);
        end
        send_line(line);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_register(REG_LINK_ADDRESS, $urandom_range(0, 255));
            case (phase)
                0: write_register(REG_MAX_BODY_LEN, MAX_BODY);
                1: write_register(REG_MAX_BODY_LEN, $urandom_range(1, 12));
                2: write_register(REG_MAX_BODY_LEN, 32'h1FFF);
                default: write_register(REG_MAX_BODY_LEN, $urandom_range(13, 300));
            endcase
            target = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target) send_random_frame();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_and_frames();
        test_address_and_limit_extremes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
